[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/hsvrgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Types and constants shared by the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int unsigned HueW    = 9;
	localparam int unsigned ChanW   = 8;
	localparam int unsigned RemW    = 6;
	localparam int unsigned TermW   = 14;  // holds 255*60
	localparam int unsigned ProdW   = 22;  // holds 255*15300
	localparam int unsigned RecipW  = 21;

	localparam logic [HueW-1:0]  HueMax    = 9'd360;
	localparam logic [RemW-1:0]  SectorDeg = 6'd60;
	localparam logic [TermW-1:0] Denom     = 14'd15300;  // 255*60

	// floor(x/15300) = floor((x>>2)/3825) = ((x>>2) * Recip3825) >> RecipShift,
	// exact for x up to 255*15300
	localparam logic [RecipW-1:0] Recip3825  = 21'd1122868;
	localparam int unsigned       RecipShift = 32;

	typedef enum logic [2:0] {
		SEC_0,
		SEC_1,
		SEC_2,
		SEC_3,
		SEC_4,
		SEC_5
	} sector_t;

	typedef struct packed {
		sector_t            sector;
		logic [RemW-1:0]    rem;
		logic               black;  // hue above 360
	} hue_dec_t;

endpackage

[sv/hsvrgb_sector.sv]
// ----------------------------------------------------------------------------
// hsvrgb_sector
// Splits a hue in degrees into a 60 degree sector and the remainder.
// ----------------------------------------------------------------------------
module hsvrgb_sector (
	input  logic [hsvrgb_pkg::HueW-1:0] hue_deg,
	output hsvrgb_pkg::hue_dec_t        dec
);

	always_comb begin
		dec.black  = 1'b0;
		dec.sector = hsvrgb_pkg::SEC_0;
		dec.rem    = '0;
		if (hue_deg > hsvrgb_pkg::HueMax) begin
			dec.black = 1'b1;
		end else if (hue_deg == hsvrgb_pkg::HueMax) begin
			dec.sector = hsvrgb_pkg::SEC_0;  // full circle wraps
		end else if (hue_deg >= 9'd300) begin
			dec.sector = hsvrgb_pkg::SEC_5;
			dec.rem    = 6'(hue_deg - 9'd300);
		end else if (hue_deg >= 9'd240) begin
			dec.sector = hsvrgb_pkg::SEC_4;
			dec.rem    = 6'(hue_deg - 9'd240);
		end else if (hue_deg >= 9'd180) begin
			dec.sector = hsvrgb_pkg::SEC_3;
			dec.rem    = 6'(hue_deg - 9'd180);
		end else if (hue_deg >= 9'd120) begin
			dec.sector = hsvrgb_pkg::SEC_2;
			dec.rem    = 6'(hue_deg - 9'd120);
		end else if (hue_deg >= 9'd60) begin
			dec.sector = hsvrgb_pkg::SEC_1;
			dec.rem    = 6'(hue_deg - 9'd60);
		end else begin
			dec.sector = hsvrgb_pkg::SEC_0;
			dec.rem    = 6'(hue_deg);
		end
	end

endmodule

[sv/hsv_to_rgb_core.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_core
// Six-sector HSV to 8-bit RGB converter, five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: hue_deg (0..360 degrees), saturation and brightness (255 = 1.0).
//   Output word: red_out, green_out, blue_out, truncated toward zero.
//   Both channels use valid/stall; a word moves when valid is high and stall
//   is low at a rising clk edge.
//   Zero saturation gives grey (all channels = brightness) for any hue.
//   Hue 360 is sector 0; hue above 360 with nonzero saturation gives black.
// An accepted word passes through the registers of s1 to s5 in order to the output.
// Throughput: one word per clock while out_stall is low. Every stage holds a valid bit and loads
//   when it is empty or the stage after it moves, so bubbles are squeezed
//   out and in_stall only rises once all five stages hold words.
// Stages: s1 sector decode, s2 S*rem and S*(60-rem), s3 V products,
//   s4 divide by 255 (add/shift) and by 15300 (reciprocal multiply),
//   s5 sector select into the output register.
// Reset: arst_n clears all valid bits; no word is in flight afterwards.
// Receiver stall: out words hold steady; upstream stages keep filling.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_to_rgb_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [hsvrgb_pkg::HueW-1:0]  hue_deg,
	input  logic [hsvrgb_pkg::ChanW-1:0] saturation,
	input  logic [hsvrgb_pkg::ChanW-1:0] brightness,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [hsvrgb_pkg::ChanW-1:0] red_out,
	output logic [hsvrgb_pkg::ChanW-1:0] green_out,
	output logic [hsvrgb_pkg::ChanW-1:0] blue_out
);

	localparam int unsigned CW = hsvrgb_pkg::ChanW;
	localparam int unsigned TW = hsvrgb_pkg::TermW;
	localparam int unsigned PW = hsvrgb_pkg::ProdW;
	localparam int unsigned QW = PW - 2 + hsvrgb_pkg::RecipW;

	// Stage enables: a stage loads when empty or when its contents move on
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	assign en_s5    = !vld_s5 || !out_stall;
	assign en_s4    = !vld_s4 || en_s5;
	assign en_s3    = !vld_s3 || en_s4;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// ---------------- s1: sector decode ----------------
	hsvrgb_pkg::hue_dec_t dec;

	hsvrgb_sector u_sector (
		.hue_deg (hue_deg),
		.dec     (dec)
	);

	hsvrgb_pkg::hue_dec_t dec_s1;
	logic [CW-1:0]        sat_s1, val_s1;
	logic                 grey_s1;

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			dec_s1  <= dec;
			sat_s1  <= saturation;
			val_s1  <= brightness;
			grey_s1 <= (saturation == '0);
		end
	end

	// ---------------- s2: numerators of P, Q, T ----------------
	logic [TW-1:0] s_rem, s_comp;

	assign s_rem  = TW'(sat_s1 * dec_s1.rem);
	assign s_comp = TW'(sat_s1 * (hsvrgb_pkg::SectorDeg - dec_s1.rem));

	logic [CW-1:0]       np_s2, val_s2;
	logic [TW-1:0]       nq_s2, nt_s2;
	hsvrgb_pkg::sector_t sec_s2;
	logic                grey_s2, black_s2;

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			np_s2    <= ~sat_s1;  // 255 - S
			nq_s2    <= hsvrgb_pkg::Denom - s_rem;
			nt_s2    <= hsvrgb_pkg::Denom - s_comp;
			val_s2   <= val_s1;
			sec_s2   <= dec_s1.sector;
			grey_s2  <= grey_s1;
			black_s2 <= dec_s1.black;
		end
	end

	// ---------------- s3: scale by V ----------------
	logic [2*CW-1:0]     pp_s3;
	logic [PW-1:0]       pq_s3, pt_s3;
	logic [CW-1:0]       val_s3;
	hsvrgb_pkg::sector_t sec_s3;
	logic                grey_s3, black_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && vld_s2) begin
			pp_s3    <= val_s2 * np_s2;
			pq_s3    <= PW'(val_s2 * nq_s2);
			pt_s3    <= PW'(val_s2 * nt_s2);
			val_s3   <= val_s2;
			sec_s3   <= sec_s2;
			grey_s3  <= grey_s2;
			black_s3 <= black_s2;
		end
	end

	// ---------------- s4: constant divides ----------------
	// x/255 = (x + 1 + (x >> 8)) >> 8, exact below 65535
	logic [2*CW:0] p_sum;
	logic [QW-1:0] q_mul, t_mul;

	assign p_sum = {1'b0, pp_s3} + (2*CW+1)'(1) + (2*CW+1)'(pp_s3[2*CW-1:CW]);
	assign q_mul = pq_s3[PW-1:2] * hsvrgb_pkg::Recip3825;
	assign t_mul = pt_s3[PW-1:2] * hsvrgb_pkg::Recip3825;

	logic [CW-1:0]       p_s4, q_s4, t_s4, val_s4;
	hsvrgb_pkg::sector_t sec_s4;
	logic                grey_s4, black_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			p_s4     <= p_sum[2*CW-1:CW];
			q_s4     <= q_mul[hsvrgb_pkg::RecipShift +: CW];
			t_s4     <= t_mul[hsvrgb_pkg::RecipShift +: CW];
			val_s4   <= val_s3;
			sec_s4   <= sec_s3;
			grey_s4  <= grey_s3;
			black_s4 <= black_s3;
		end
	end

	// ---------------- s5: sector select, output register ----------------
	logic [CW-1:0] r_nxt, g_nxt, b_nxt;

	always_comb begin
		r_nxt = val_s4;
		g_nxt = t_s4;
		b_nxt = p_s4;
		if (grey_s4) begin
			r_nxt = val_s4;
			g_nxt = val_s4;
			b_nxt = val_s4;
		end else if (black_s4) begin
			r_nxt = '0;
			g_nxt = '0;
			b_nxt = '0;
		end else begin
			case (sec_s4)
				hsvrgb_pkg::SEC_1: begin
					r_nxt = q_s4;   g_nxt = val_s4; b_nxt = p_s4;
				end
				hsvrgb_pkg::SEC_2: begin
					r_nxt = p_s4;   g_nxt = val_s4; b_nxt = t_s4;
				end
				hsvrgb_pkg::SEC_3: begin
					r_nxt = p_s4;   g_nxt = q_s4;   b_nxt = val_s4;
				end
				hsvrgb_pkg::SEC_4: begin
					r_nxt = t_s4;   g_nxt = p_s4;   b_nxt = val_s4;
				end
				hsvrgb_pkg::SEC_5: begin
					r_nxt = val_s4; g_nxt = p_s4;   b_nxt = q_s4;
				end
				default: begin
					r_nxt = val_s4; g_nxt = t_s4;   b_nxt = p_s4;
				end
			endcase
		end
	end

	logic [CW-1:0] red_s5, green_s5, blue_s5;

	always_ff @(posedge clk) begin
		if (en_s5 && vld_s4) begin
			red_s5   <= r_nxt;
			green_s5 <= g_nxt;
			blue_s5  <= b_nxt;
		end
	end

	assign out_valid = vld_s5;
	assign red_out   = red_s5;
	assign green_out = green_s5;
	assign blue_out  = blue_s5;

	// ---------------- checks ----------------
	`ASSERT_ALWAYS(a_rst_empty, clk, !arst_n |-> !vld_s1 && !vld_s5, "pipe not empty in reset")
	`ASSERT_CLK(a_s1_hold, clk, arst_n, vld_s1 && !en_s2 |=> vld_s1 && $stable(val_s1) && $stable(sat_s1), "stage 1 lost word while blocked")
	`ASSERT_CLK(a_grey, clk, arst_n, vld_s4 && grey_s4 && en_s5 |=> red_out == green_out && green_out == blue_out, "grey word not grey")
	`ASSERT_CLK(a_black, clk, arst_n, vld_s4 && black_s4 && !grey_s4 && en_s5 |=> red_out == '0 && green_out == '0 && blue_out == '0, "out of range hue not black")

endmodule

[tb/sv/hsv_to_rgb_core_tb.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_core_tb
// Self-checking bench for the HSV to RGB converter. A directed table covers
// the sector corners, grey, the wrap at 360 degrees and out-of-range hues.
// Random words follow, with idle bursts on both channels and one long
// receiver hold-off. Every accepted word is scored against its typed color
// or a local six-sector model.
// ----------------------------------------------------------------------------
module hsv_to_rgb_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hsvrgb_pkg::*;

	localparam int unsigned ClkHalf    = 6;       // 12 ns period
	localparam int unsigned RandWords  = 400;
	localparam int unsigned CalmWords  = 60;      // tail of the run with no idling
	localparam int unsigned HoldAt     = 150;     // words accepted before the long hold
	localparam int unsigned HoldLen    = 80;      // well past the five pipeline stages
	localparam int unsigned DrainWait  = 12;      // margin after the last owed word comes out
	localparam int unsigned CycleLimit = 100000;  // ~425 words * worst gaps, many times over
	localparam int unsigned ShowErrs   = 10;

	// Scaled arithmetic constants: 255 is 1.0, one sector spans 60 degrees.
	localparam int unsigned Full    = 255;
	localparam int unsigned SecSpan = 60;
	localparam int unsigned Scale   = 15300;      // Full * SecSpan
	localparam int unsigned HueTop  = 360;

	typedef struct packed {
		logic [ChanW-1:0] r;
		logic [ChanW-1:0] g;
		logic [ChanW-1:0] b;
	} rgb_t;

	typedef struct {
		logic [HueW-1:0]  hue;
		logic [ChanW-1:0] sat;
		logic [ChanW-1:0] val;
		bit               known;  // color typed in below
		rgb_t             color;
	} hsv_row_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [HueW-1:0]  hue_deg;
	logic [ChanW-1:0] saturation;
	logic [ChanW-1:0] brightness;
	logic             out_valid;
	logic             out_stall;
	logic [ChanW-1:0] red_out;
	logic [ChanW-1:0] green_out;
	logic [ChanW-1:0] blue_out;

	rgb_t        rgb_pending[$];    // colors owed by the pipeline, oldest first
	int unsigned err_count  = 0;
	int unsigned words_in   = 0;
	int unsigned cycles     = 0;
	bit          idle_on    = 1'b1;  // random bursts allowed on both sides
	bit          held_long  = 1'b0;

	hsv_to_rgb_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.hue_deg    (hue_deg),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#(ClkHalf) clk = ~clk;
		end
	end

	// Six-sector conversion in exact integer math, truncating each term.
	// Grey wins over everything, even hues past 360; those give black otherwise.
	function automatic rgb_t hsv_predict(logic [HueW-1:0] h, logic [ChanW-1:0] s,
			logic [ChanW-1:0] v);
		int unsigned hue_i;
		int unsigned rem;
		int unsigned term_p;
		int unsigned term_q;
		int unsigned term_t;
		sector_t     sec;
		rgb_t        c;
		hue_i = h;
		c = '0;
		if (s == 0) begin
			c = '{v, v, v};
		end else if (hue_i <= HueTop) begin
			// 360 lands on 6 with rem 0; the default arm folds it into sector 0
			sec    = sector_t'(hue_i / SecSpan);
			rem    = hue_i % SecSpan;
			term_p = (v * (Full - s)) / Full;
			term_q = (v * (Scale - s * rem)) / Scale;
			term_t = (v * (Scale - s * (SecSpan - rem))) / Scale;
			case (sec)
				SEC_1: c = '{term_q[7:0], v, term_p[7:0]};
				SEC_2: c = '{term_p[7:0], v, term_t[7:0]};
				SEC_3: c = '{term_p[7:0], term_q[7:0], v};
				SEC_4: c = '{term_t[7:0], term_p[7:0], v};
				SEC_5: c = '{v, term_p[7:0], term_q[7:0]};
				default: c = '{v, term_t[7:0], term_p[7:0]};
			endcase
		end
		return c;
	endfunction

	task automatic flag_error(string msg);
		err_count++;
		if (err_count <= ShowErrs) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the word is
	// taken. Valid stays up across back-to-back words, dropped only for gaps.
	task automatic send_word(logic [HueW-1:0] h, logic [ChanW-1:0] s,
			logic [ChanW-1:0] v, bit known, rgb_t color);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		hue_deg    <= h;
		saturation <= s;
		brightness <= v;
		do begin
			@(posedge clk);
		end while (in_stall);
		rgb_pending.push_back(known ? color : hsv_predict(h, s, v));
		words_in++;
		@(negedge clk);
	endtask

	// Output scoreboard: compare every taken word with the oldest owed color.
	always @(posedge clk) begin : score
		rgb_t got;
		rgb_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{red_out, green_out, blue_out};
			if (rgb_pending.size() == 0) begin
				flag_error($sformatf("unexpected word rgb=%0d,%0d,%0d",
					got.r, got.g, got.b));
			end else begin
				want = rgb_pending.pop_front();
				if (got.r !== want.r || got.g !== want.g || got.b !== want.b) begin
					flag_error($sformatf("mismatch: want rgb=%0d,%0d,%0d got %0d,%0d,%0d",
						want.r, want.g, want.b, got.r, got.g, got.b));
				end
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off once enough words
	// are in so the five stages fill and in_stall must rise.
	initial begin : receiver
		int unsigned stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (idle_on && $urandom_range(0, 4) == 0) begin
					stall_left = $urandom_range(1, 11);
				end
			end
			if (!held_long && words_in >= HoldAt) begin
				held_long  = 1'b1;
				stall_left = HoldLen;
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("hsv_to_rgb_core_tb: errors");
			$finish;
		end
	end

	initial begin : stimulus
		hsv_row_t    dir_rows[$];
		logic [HueW-1:0]  h;
		logic [ChanW-1:0] s;
		logic [ChanW-1:0] v;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		hue_deg    = '0;
		saturation = '0;
		brightness = '0;

		// Directed words. Colors are typed where they follow straight from the
		// definition: grey, black, and full-saturation sector corners.
		dir_rows = '{
			'{9'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
			'{9'd0,   8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
			'{9'd511, 8'd0,   8'd128, 1'b1, '{8'd128, 8'd128, 8'd128}},  // grey beats range
			'{9'd361, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd0}},    // just past 360
			'{9'd511, 8'd1,   8'd255, 1'b1, '{8'd0,   8'd0,   8'd0}},
			'{9'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
			'{9'd60,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
			'{9'd120, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
			'{9'd180, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
			'{9'd240, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
			'{9'd300, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
			'{9'd360, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},    // wraps to sector 0
			'{9'd0,   8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
			'{9'd59,  8'd255, 8'd255, 1'b0, '0},
			'{9'd119, 8'd128, 8'd200, 1'b0, '0},
			'{9'd179, 8'd254, 8'd254, 1'b0, '0},
			'{9'd239, 8'd1,   8'd1,   1'b0, '0},
			'{9'd299, 8'd170, 8'd85,  1'b0, '0},
			'{9'd359, 8'd255, 8'd255, 1'b0, '0},
			'{9'd360, 8'd100, 8'd77,  1'b0, '0},
			'{9'd30,  8'd85,  8'd170, 1'b0, '0},
			'{9'd256, 8'd170, 8'd85,  1'b0, '0},
			'{9'd255, 8'd1,   8'd255, 1'b0, '0},
			'{9'd400, 8'd128, 8'd1,   1'b0, '0}
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].hue, dir_rows[i].sat, dir_rows[i].val,
				dir_rows[i].known, dir_rows[i].color);
		end

		// Random words: hues mostly in range with sector edges favored, a slice
		// past 360; saturation leans on 0, 1 and 255 now and then, value on 0 and 255.
		for (int unsigned n = 0; n < RandWords; n++) begin
			if (n == RandWords - CalmWords) begin
				idle_on = 1'b0;
			end
			case ($urandom_range(0, 9))
				0:       h = HueW'($urandom_range(361, 511));
				1:       h = HueW'(SecSpan * $urandom_range(0, 6));
				2:       h = HueW'(SecSpan * $urandom_range(1, 6) - 1);
				default: h = HueW'($urandom_range(0, HueTop));
			endcase
			case ($urandom_range(0, 9))
				0:       s = 8'd0;
				1:       s = 8'd255;
				2:       s = 8'd1;
				default: s = ChanW'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 9))
				0:       v = 8'd0;
				1:       v = 8'd255;
				default: v = ChanW'($urandom_range(0, 255));
			endcase
			send_word(h, s, v, 1'b0, '0);
		end
		in_valid <= 1'b0;

		// Drain; the watchdog catches a pipeline that never empties.
		while (rgb_pending.size() > 0) begin
			@(posedge clk);
		end
		repeat (DrainWait) @(posedge clk);

		if (err_count == 0 && rgb_pending.size() == 0) begin
			$display("hsv_to_rgb_core_tb: clean");
		end else begin
			$display("hsv_to_rgb_core_tb: errors");
		end
		$finish;
	end

endmodule
